[src/codk_pkg.sv]
package codk_pkg;

    localparam int TIME_FRAC_BITS_DEF = 32;
    localparam int COV_FRAC_BITS_DEF  = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_SIGMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_NV  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_EN   = 2'd3;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] CHI2_GATE_Q32 = 64'sd28496663914;
    // ceil(2^65 / 3): exact third of any 64-bit magnitude after a shift by 65
    localparam logic [63:0]        RCP3_Q65 = 64'hAAAA_AAAA_AAAA_AAAB;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_MULU, OP_MULDIV, OP_CLAMP1, OP_GT, OP_END
    } t_op;

    typedef enum logic [2:0] {
        SH_T, SH_Q, SH_E, SH_S, SH_32, SH_1, SH_65
    } t_sh;

    localparam int MEM_DEPTH = 16;
    localparam int MEM_AW    = 4;

    // operand codes: below 16 a scratch entry, from 16 up a fixed source
    localparam logic [4:0] R_Y    = 5'd0;
    localparam logic [4:0] R_DT   = 5'd1;
    localparam logic [4:0] R_M    = 5'd2;
    localparam logic [4:0] R_XB   = 5'd3;
    localparam logic [4:0] R_P01  = 5'd4;
    localparam logic [4:0] R_P00  = 5'd5;
    localparam logic [4:0] R_Q11  = 5'd6;
    localparam logic [4:0] R_T2   = 5'd7;
    localparam logic [4:0] R_T3   = 5'd8;
    localparam logic [4:0] R_P11  = 5'd9;
    localparam logic [4:0] R_PYY  = 5'd10;
    localparam logic [4:0] R_INN  = 5'd11;
    localparam logic [4:0] R_LIM  = 5'd12;
    localparam logic [4:0] S_LT    = 5'd16;
    localparam logic [4:0] S_RT    = 5'd17;
    localparam logic [4:0] S_SIG   = 5'd18;
    localparam logic [4:0] S_SB    = 5'd19;
    localparam logic [4:0] S_SD    = 5'd20;
    localparam logic [4:0] S_CHI   = 5'd21;
    localparam logic [4:0] S_ONE   = 5'd22;
    localparam logic [4:0] S_RCP3  = 5'd24;
    localparam logic [4:0] S_ZERO  = 5'd25;
    localparam logic [4:0] S_BIAS  = 5'd26;
    localparam logic [4:0] S_DRIFT = 5'd27;
    localparam logic [4:0] S_CBB   = 5'd28;
    localparam logic [4:0] S_CBD   = 5'd29;
    localparam logic [4:0] S_CDD   = 5'd30;
    localparam logic [4:0] S_LUT   = 5'd31;

    typedef struct packed {
        t_op        op;
        t_sh        sh;
        logic [4:0] dst;
        logic [4:0] sa;
        logic [4:0] sb;
        logic [4:0] sd;
    } t_ins;

    localparam int PROG_LEN = 38;
    localparam int PC_W     = $clog2(PROG_LEN);

    localparam t_ins PROG [PROG_LEN] = '{
        '{OP_SUB,    SH_T,  R_Y,     S_LT,    S_RT,    S_ZERO},
        '{OP_SUB,    SH_T,  R_DT,    S_LT,    S_LUT,   S_ZERO},
        '{OP_MUL,    SH_T,  R_M,     S_DRIFT, R_DT,    S_ZERO},
        '{OP_ADD,    SH_T,  R_XB,    S_BIAS,  R_M,     S_ZERO},
        '{OP_MUL,    SH_T,  R_M,     R_DT,    S_CDD,   S_ZERO},
        '{OP_ADD,    SH_T,  R_P01,   S_CBD,   R_M,     S_ZERO},
        '{OP_MUL,    SH_T,  R_M,     R_DT,    S_CBD,   S_ZERO},
        '{OP_ADD,    SH_T,  R_P00,   S_CBB,   R_M,     S_ZERO},
        '{OP_MUL,    SH_T,  R_M,     R_DT,    R_P01,   S_ZERO},
        '{OP_ADD,    SH_T,  R_P00,   R_P00,   R_M,     S_ZERO},
        '{OP_MUL,    SH_Q,  R_Q11,   R_DT,    S_SD,    S_ZERO},
        '{OP_MUL,    SH_T,  R_T2,    R_DT,    R_Q11,   S_ZERO},
        '{OP_MUL,    SH_T,  R_T3,    R_DT,    R_T2,    S_ZERO},
        '{OP_MULU,   SH_65, R_T3,    R_T3,    S_RCP3,  S_ZERO},
        '{OP_MUL,    SH_Q,  R_M,     R_DT,    S_SB,    S_ZERO},
        '{OP_ADD,    SH_T,  R_M,     R_M,     R_T3,    S_ZERO},
        '{OP_ADD,    SH_T,  R_P00,   R_P00,   R_M,     S_ZERO},
        '{OP_MUL,    SH_1,  R_M,     R_T2,    S_ONE,   S_ZERO},
        '{OP_ADD,    SH_T,  R_P01,   R_P01,   R_M,     S_ZERO},
        '{OP_ADD,    SH_T,  R_P11,   S_CDD,   R_Q11,   S_ZERO},
        '{OP_MUL,    SH_S,  R_M,     S_SIG,   S_SIG,   S_ZERO},
        '{OP_ADD,    SH_T,  R_PYY,   R_P00,   R_M,     S_ZERO},
        '{OP_CLAMP1, SH_T,  R_PYY,   R_PYY,   S_ZERO,  S_ZERO},
        '{OP_SUB,    SH_T,  R_INN,   R_Y,     R_XB,    S_ZERO},
        '{OP_MUL,    SH_E,  R_M,     R_INN,   R_INN,   S_ZERO},
        '{OP_MUL,    SH_32, R_LIM,   S_CHI,   R_PYY,   S_ZERO},
        '{OP_GT,     SH_T,  S_ZERO,  R_M,     R_LIM,   S_ZERO},
        '{OP_MULDIV, SH_T,  R_M,     R_P00,   R_INN,   R_PYY},
        '{OP_ADD,    SH_T,  S_BIAS,  R_XB,    R_M,     S_ZERO},
        '{OP_MULDIV, SH_T,  R_M,     R_P01,   R_INN,   R_PYY},
        '{OP_ADD,    SH_T,  S_DRIFT, S_DRIFT, R_M,     S_ZERO},
        '{OP_MULDIV, SH_T,  R_M,     R_P00,   R_P00,   R_PYY},
        '{OP_SUB,    SH_T,  S_CBB,   R_P00,   R_M,     S_ZERO},
        '{OP_MULDIV, SH_T,  R_M,     R_P00,   R_P01,   R_PYY},
        '{OP_SUB,    SH_T,  S_CBD,   R_P01,   R_M,     S_ZERO},
        '{OP_MULDIV, SH_T,  R_M,     R_P01,   R_P01,   R_PYY},
        '{OP_SUB,    SH_T,  S_CDD,   R_P11,   R_M,     S_ZERO},
        '{OP_END,    SH_T,  S_LUT,   S_LT,    S_ZERO,  S_ZERO}
    };

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_ISSUE, S_RD_AB, S_RD_D, S_LAT_D,
        S_MUL, S_DIV, S_WB, S_NEXT, S_EMIT
    } t_state;

    typedef struct packed {
        logic       cap_in;
        logic       clr_est;
        logic       seed;
        logic       rd_ab;
        logic       rd_d;
        logic       lat_d;
        logic       mul_pp;
        logic       mul_acc;
        logic [1:0] mul_k;
        logic       div_init;
        logic       div_step;
        logic       wb;
        logic       load_out;
        logic       acc;
        t_ins       ins;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic have;
        logic gate_en;
        logic flag;
    } t_stat;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] from_mag(input logic [127:0] m,
                                                    input logic neg);
        logic [63:0] lo;
        lo = m[63:0];
        if (m[127:64] != 64'd0) return neg ? S64_MIN : S64_MAX;
        if (neg) begin
            if (lo > 64'h8000_0000_0000_0000) return S64_MIN;
            return 64'd0 - lo;
        end
        if (lo[63]) return S64_MAX;
        return lo;
    endfunction

endpackage

[src/codk_ctrl.sv]
module codk_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  codk_pkg::t_stat i_stat,
    output codk_pkg::t_cmd  o_cmd
);
    import codk_pkg::*;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc;
    logic [7:0]      r_cnt;
    logic            r_acc;
    logic            r_out_valid;
    t_ins            w_ins;
    logic            w_fire;
    logic            w_emit_ok;
    logic            w_reject;

    assign w_ins     = PROG[r_pc];
    assign w_fire    = i_in_valid && (r_state == S_IDLE);
    assign w_emit_ok = !r_out_valid || i_out_ready;
    assign w_reject  = (w_ins.op == OP_GT) && i_stat.gate_en && i_stat.flag;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_fire) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.kind || !i_stat.have) n_state = S_EMIT;
                else n_state = S_ISSUE;
            end
            S_ISSUE:  n_state = (w_ins.op == OP_END) ? S_EMIT : S_RD_AB;
            S_RD_AB:  n_state = S_RD_D;
            S_RD_D:   n_state = S_LAT_D;
            S_LAT_D: begin
                if (w_ins.op == OP_MUL || w_ins.op == OP_MULU || w_ins.op == OP_MULDIV)
                    n_state = S_MUL;
                else n_state = S_WB;
            end
            S_MUL: begin
                if (r_cnt == 8'd4) n_state = (w_ins.op == OP_MULDIV) ? S_DIV : S_WB;
            end
            S_DIV:    if (r_cnt == 8'd128) n_state = S_WB;
            S_WB:     n_state = S_NEXT;
            S_NEXT:   n_state = w_reject ? S_EMIT : S_ISSUE;
            S_EMIT:   if (w_emit_ok) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.ins      = w_ins;
        o_cmd.acc      = r_acc;
        o_cmd.mul_k    = r_cnt[1:0];
        case (r_state)
            S_IDLE:   o_cmd.cap_in = w_fire;
            S_DECIDE: begin
                o_cmd.clr_est = i_stat.kind;
                o_cmd.seed    = !i_stat.kind && !i_stat.have;
            end
            S_RD_AB:  o_cmd.rd_ab = 1'b1;
            S_RD_D:   o_cmd.rd_d  = 1'b1;
            S_LAT_D:  o_cmd.lat_d = 1'b1;
            S_MUL: begin
                o_cmd.mul_pp  = (r_cnt < 8'd4);
                o_cmd.mul_acc = (r_cnt != 8'd0);
            end
            S_DIV: begin
                o_cmd.div_init = (r_cnt == 8'd0);
                o_cmd.div_step = (r_cnt != 8'd0);
            end
            S_WB:     o_cmd.wb = 1'b1;
            S_EMIT:   o_cmd.load_out = w_emit_ok;
            default:  o_cmd.ins = w_ins;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_cnt       <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECIDE) begin
                r_pc  <= '0;
                r_acc <= !i_stat.kind;
            end
            if (r_state == S_ISSUE && w_ins.op == OP_END) r_acc <= 1'b1;
            if (r_state == S_NEXT) begin
                if (w_reject) r_acc <= 1'b0;
                else r_pc <= r_pc + 1'b1;
            end
            if (r_state == S_LAT_D) r_cnt <= '0;
            else if (r_state == S_MUL) r_cnt <= (r_cnt == 8'd4) ? 8'd0 : r_cnt + 8'd1;
            else if (r_state == S_DIV) r_cnt <= r_cnt + 8'd1;
            if (o_cmd.load_out) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken one");
    a_fire_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_state == S_DECIDE))
        else $error("request not decoded after accept");
    a_mul_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt <= 8'd4))
        else $error("multiply step count out of range");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < PC_W'(PROG_LEN))
        else $error("program counter past end");
`endif

endmodule

[src/codk_dp.sv]
module codk_dp #(
    parameter int TIME_FRAC_BITS = codk_pkg::TIME_FRAC_BITS_DEF,
    parameter int COV_FRAC_BITS  = codk_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  codk_pkg::t_cmd                    i_cmd,
    output codk_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [codk_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [codk_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_kind,
    input  logic signed [63:0]                i_local_time,
    input  logic signed [63:0]                i_remote_time,
    input  logic [31:0]                       i_meas_sigma,
    input  logic                              i_use_default_sigma,
    output logic                              o_accepted,
    output logic                              o_initialized,
    output logic                              o_synced,
    output logic signed [63:0]                o_bias_out,
    output logic signed [63:0]                o_drift_out,
    output logic signed [63:0]                o_bias_variance,
    output logic signed [63:0]                o_drift_variance
);
    import codk_pkg::*;

    localparam int SHV_T  = TIME_FRAC_BITS;
    localparam int SHV_Q  = TIME_FRAC_BITS + 32 - COV_FRAC_BITS;
    localparam int SHV_E  = 2 * TIME_FRAC_BITS - COV_FRAC_BITS;
    localparam int SHV_S  = 32 - COV_FRAC_BITS;
    localparam int SHV_32 = 32;
    localparam int SHV_1  = 1;
    localparam int SHV_65 = 65;
    localparam logic [63:0] TEN_C = 64'd10 << COV_FRAC_BITS;
    localparam logic signed [63:0] SYNC_THR = (64'd81 << COV_FRAC_BITS) / 64'd10000;

    logic [31:0]        r_def_sigma, r_sb, r_sd;
    logic               r_gate;
    logic               r_kind;
    logic signed [63:0] r_lt, r_rt;
    logic [31:0]        r_sigma;
    logic               r_have;
    logic signed [63:0] r_lut, r_bias, r_drift, r_cbb, r_cbd, r_cdd;
    logic               r_flag;
    logic signed [63:0] r_mem [MEM_DEPTH];
    logic signed [63:0] r_rda, r_rdb;
    logic signed [63:0] r_a, r_b, r_d;
    logic [63:0]        r_pp;
    logic [1:0]         r_pp_k;
    logic [127:0]       r_acc;
    logic [127:0]       r_q;
    logic [63:0]        r_rem;

    logic [4:0]         w_addr_a;
    logic               w_b_signed;
    logic [63:0]        w_ua, w_ub;
    logic               w_neg;
    logic [31:0]        w_ah, w_bh;
    logic signed [63:0] w_mul_res, w_div_res, w_res;
    logic [64:0]        w_trial;
    int                 w_shv;
    logic [127:0]       w_shm;
    logic               w_ovf;

    function automatic logic signed [63:0] spec_val(input logic [4:0] code,
        input logic signed [63:0] lt, input logic signed [63:0] rt,
        input logic [31:0] sig, input logic [31:0] sb, input logic [31:0] sd,
        input logic signed [63:0] bias, input logic signed [63:0] drift,
        input logic signed [63:0] cbb, input logic signed [63:0] cbd,
        input logic signed [63:0] cdd, input logic signed [63:0] lut);
        logic signed [63:0] v;
        case (code)
            S_LT:    v = lt;
            S_RT:    v = rt;
            S_SIG:   v = {32'd0, sig};
            S_SB:    v = {32'd0, sb};
            S_SD:    v = {32'd0, sd};
            S_CHI:   v = CHI2_GATE_Q32;
            S_ONE:   v = 64'sd1;
            S_RCP3:  v = RCP3_Q65;
            S_BIAS:  v = bias;
            S_DRIFT: v = drift;
            S_CBB:   v = cbb;
            S_CBD:   v = cbd;
            S_CDD:   v = cdd;
            S_LUT:   v = lut;
            default: v = 64'sd0;
        endcase
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_sigma <= 32'd65536;
            r_sb        <= '0;
            r_sd        <= '0;
            r_gate      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEF_SIGMA: r_def_sigma <= i_cfg_data;
                CFG_BIAS_NV:   r_sb        <= i_cfg_data;
                CFG_DRIFT_NV:  r_sd        <= i_cfg_data;
                CFG_GATE_EN:   r_gate      <= i_cfg_data[0];
                default:       r_gate      <= r_gate;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_kind  <= i_kind;
            r_lt    <= i_local_time;
            r_rt    <= i_remote_time;
            r_sigma <= i_use_default_sigma ? r_def_sigma : i_meas_sigma;
        end
    end

    // operand fetch
    assign w_addr_a = i_cmd.rd_d ? i_cmd.ins.sd : i_cmd.ins.sa;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ab || i_cmd.rd_d) begin
            r_rda <= w_addr_a[4] ? spec_val(w_addr_a, r_lt, r_rt, r_sigma, r_sb, r_sd,
                                            r_bias, r_drift, r_cbb, r_cbd, r_cdd, r_lut)
                                 : r_mem[w_addr_a[MEM_AW-1:0]];
        end
        if (i_cmd.rd_ab) begin
            r_rdb <= i_cmd.ins.sb[4] ? spec_val(i_cmd.ins.sb, r_lt, r_rt, r_sigma, r_sb,
                                                r_sd, r_bias, r_drift, r_cbb, r_cbd,
                                                r_cdd, r_lut)
                                     : r_mem[i_cmd.ins.sb[MEM_AW-1:0]];
        end
        if (i_cmd.rd_d) begin
            r_a <= r_rda;
            r_b <= r_rdb;
        end
        if (i_cmd.lat_d) r_d <= r_rda;
        if (i_cmd.wb && !i_cmd.ins.dst[4]) r_mem[i_cmd.ins.dst[MEM_AW-1:0]] <= w_res;
    end

    // multiply over four 32x32 partial products
    assign w_b_signed = (i_cmd.ins.op != OP_MULU);
    assign w_ua  = r_a[63] ? 64'd0 - r_a : r_a;
    assign w_ub  = (r_b[63] && w_b_signed) ? 64'd0 - r_b : r_b;
    assign w_neg = r_a[63] ^ (r_b[63] && w_b_signed);
    assign w_ah  = i_cmd.mul_k[1] ? w_ua[63:32] : w_ua[31:0];
    assign w_bh  = i_cmd.mul_k[0] ? w_ub[63:32] : w_ub[31:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_pp) begin
            r_pp   <= w_ah * w_bh;
            r_pp_k <= {1'b0, i_cmd.mul_k[1]} + {1'b0, i_cmd.mul_k[0]};
        end
        if (i_cmd.lat_d) r_acc <= '0;
        else if (i_cmd.mul_acc) r_acc <= r_acc + ({64'd0, r_pp} << (7'd32 * r_pp_k));
    end

    // restoring divide, one quotient bit a step
    assign w_trial = {r_rem, r_q[127]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_q   <= r_acc;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_d}) begin
                r_rem <= 64'(w_trial - {1'b0, r_d});
                r_q   <= {r_q[126:0], 1'b1};
            end else begin
                r_rem <= w_trial[63:0];
                r_q   <= {r_q[126:0], 1'b0};
            end
        end
    end

    always_comb begin
        case (i_cmd.ins.sh)
            SH_T:    w_shv = SHV_T;
            SH_Q:    w_shv = SHV_Q;
            SH_E:    w_shv = SHV_E;
            SH_S:    w_shv = SHV_S;
            SH_32:   w_shv = SHV_32;
            SH_1:    w_shv = SHV_1;
            SH_65:   w_shv = SHV_65;
            default: w_shv = SHV_T;
        endcase
        if (w_shv >= 0) begin
            w_shm = r_acc >> w_shv;
            w_ovf = 1'b0;
        end else begin
            w_shm = r_acc << (-w_shv);
            w_ovf = (r_acc >> (64 + w_shv)) != 128'd0;
        end
        w_mul_res = w_ovf ? (w_neg ? S64_MIN : S64_MAX) : from_mag(w_shm, w_neg);
        w_div_res = from_mag(r_q, w_neg);
    end

    always_comb begin
        case (i_cmd.ins.op)
            OP_ADD:    w_res = sat_add(r_a, r_b);
            OP_SUB:    w_res = sat_sub(r_a, r_b);
            OP_MUL:    w_res = w_mul_res;
            OP_MULU:   w_res = w_mul_res;
            OP_MULDIV: w_res = w_div_res;
            OP_CLAMP1: w_res = (r_a < 64'sd1) ? 64'sd1 : r_a;
            default:   w_res = 64'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_lut   <= '0;
            r_bias  <= '0;
            r_drift <= '0;
            r_cbb   <= '0;
            r_cbd   <= '0;
            r_cdd   <= '0;
            r_flag  <= 1'b0;
        end else if (i_cmd.clr_est) begin
            r_have  <= 1'b0;
            r_lut   <= '0;
            r_bias  <= '0;
            r_drift <= '0;
            r_cbb   <= '0;
            r_cbd   <= '0;
            r_cdd   <= '0;
        end else if (i_cmd.seed) begin
            r_have  <= 1'b1;
            r_lut   <= r_lt;
            r_bias  <= sat_sub(r_lt, r_rt);
            r_drift <= '0;
            r_cbb   <= TEN_C;
            r_cbd   <= '0;
            r_cdd   <= TEN_C;
        end else if (i_cmd.wb) begin
            if (i_cmd.ins.op == OP_GT) r_flag <= (r_a > r_b);
            else if (i_cmd.ins.dst[4]) begin
                case (i_cmd.ins.dst)
                    S_BIAS:  r_bias  <= w_res;
                    S_DRIFT: r_drift <= w_res;
                    S_CBB:   r_cbb   <= w_res;
                    S_CBD:   r_cbd   <= w_res;
                    S_CDD:   r_cdd   <= w_res;
                    default: r_flag  <= r_flag;
                endcase
            end
        end else if (i_cmd.ins.op == OP_END && i_cmd.load_out && i_cmd.acc) begin
            r_lut <= r_lt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_accepted       <= i_cmd.acc;
            o_initialized    <= r_have;
            o_synced         <= r_have && (sat_add(r_cbb, r_cdd) <= SYNC_THR);
            o_bias_out       <= r_have ? r_bias  : 64'sd0;
            o_drift_out      <= r_have ? r_drift : 64'sd0;
            o_bias_variance  <= r_have ? r_cbb   : 64'sd0;
            o_drift_variance <= r_have ? r_cdd   : 64'sd0;
        end
    end

    assign o_stat.kind    = r_kind;
    assign o_stat.have    = r_have;
    assign o_stat.gate_en = r_gate;
    assign o_stat.flag    = r_flag;

endmodule

[src/clock_offset_drift_kalman_unit.sv]
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/s_axis_tready  tdata: times, sigma; tuser: kind
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata: flags, estimate, variances
// cfg        in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
// A reset request or the first measurement goes from decode straight to the output
// register. A full update runs the whole program, its five update quotients from
// the bit-serial divider at 128 steps each; a gated one ends before any divide.
// Reset is synchronous and active low; no clearing pass follows it.
// A new request is taken once the previous one has reached the output
// register, even while that result still waits on m_axis_tready.
module clock_offset_drift_kalman_unit #(
    parameter int TIME_FRAC_BITS = codk_pkg::TIME_FRAC_BITS_DEF,
    parameter int COV_FRAC_BITS  = codk_pkg::COV_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // local_time[63:0], remote_time[127:64], meas_sigma[159:128],
    // use_default_sigma[160], zero fill
    input  logic [167:0]                    s_axis_tdata,
    // kind[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // accepted[0], initialized[1], synced[2], bias_out[66:3], drift_out[130:67],
    // bias_variance[194:131], drift_variance[258:195], zero fill
    output logic [263:0]                    m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [codk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [codk_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import codk_pkg::*;

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic               w_accepted, w_initialized, w_synced;
    logic signed [63:0] w_bias, w_drift, w_bvar, w_dvar;

    codk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    codk_dp #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .COV_FRAC_BITS  (COV_FRAC_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (s_axis_tuser[0]),
        .i_local_time        (s_axis_tdata[63:0]),
        .i_remote_time       (s_axis_tdata[127:64]),
        .i_meas_sigma        (s_axis_tdata[159:128]),
        .i_use_default_sigma (s_axis_tdata[160]),
        .o_accepted          (w_accepted),
        .o_initialized       (w_initialized),
        .o_synced            (w_synced),
        .o_bias_out          (w_bias),
        .o_drift_out         (w_drift),
        .o_bias_variance     (w_bvar),
        .o_drift_variance    (w_dvar)
    );

    assign m_axis_tdata = {5'd0, w_dvar, w_bvar, w_drift, w_bias,
                           w_synced, w_initialized, w_accepted};

endmodule
